// ===== design/csa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the current sensor averager: register
// indexes, reset values, the configuration bundle and the result record.
// ----------------------------------------------------------------------------
package csa_pkg;

	localparam int MV_W           = 12;
	localparam int WIN_REG_W      = 11;
	localparam int LEVEL_W        = 16;
	localparam int COEF_W         = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int MAX_WINDOW_DEF = 1024;
	localparam int JOB_DEPTH      = 2;
	localparam int RES_DEPTH      = 2;
	localparam int LEVEL_FRAC     = 12;
	localparam int GAIN_FRAC      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SAMPLES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_INV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MA_PER_MV    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR  = 3'd4;

	localparam logic [WIN_REG_W-1:0] ZERO_SAMPLES_RST = 11'd64;
	localparam logic [WIN_REG_W-1:0] READ_SAMPLES_RST = 11'd16;
	localparam logic [COEF_W-1:0]    DIVIDER_INV_RST  = 16'd6144;
	localparam logic [COEF_W-1:0]    MA_PER_MV_RST    = 16'd1384;
	localparam logic [COEF_W-1:0]    NOISE_FLOOR_RST  = 16'd0;

	localparam logic [LEVEL_W-1:0] ZERO_MIN_MV = 16'd1800;
	localparam logic [LEVEL_W-1:0] ZERO_MAX_MV = 16'd3200;

	localparam logic KIND_CAL  = 1'b0;
	localparam logic KIND_MEAS = 1'b1;

	typedef struct packed {
		logic [WIN_REG_W-1:0] zero_samples;
		logic [WIN_REG_W-1:0] read_samples;
		logic [COEF_W-1:0]    divider_inv_q12;
		logic [COEF_W-1:0]    ma_per_mv_q8;
		logic [COEF_W-1:0]    noise_floor_ma;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic               ok;
		logic [COEF_W-1:0]  current_ma;
		logic [LEVEL_W-1:0] zero_level_mv;
	} result_t;

endpackage
`default_nettype wire

// ===== design/csa_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_fifo
// Small register queue with push/full and pop/empty; the head entry is
// shown while empty is low.
// ----------------------------------------------------------------------------
module csa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== design/csa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_front
// Sample accumulator: sums samples, tracks calibration mode and hands a
// finished window (sum, count, kind) to the back end.
// ----------------------------------------------------------------------------
module csa_front #(
	parameter int MAX_WINDOW = csa_pkg::MAX_WINDOW_DEF,
	parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
	parameter int SUM_W      = csa_pkg::MV_W + CNT_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [csa_pkg::MV_W-1:0] adc_mv,
	input  logic                     recalibrate,
	input  csa_pkg::cfg_t            cfg,
	output logic                     job_push,
	output logic                     job_kind,
	output logic [SUM_W-1:0]         job_sum,
	output logic [CNT_W-1:0]         job_cnt
);
	import csa_pkg::*;

	logic                 cal_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 cal_next;
	logic [SUM_W-1:0]     sum_new;
	logic [CNT_W-1:0]     cnt_new;
	logic [WIN_REG_W-1:0] win_reg;
	logic [CNT_W-1:0]     win_len;
	logic                 win_done;

	always_comb begin
		cal_next = recalibrate || cal_q;
		sum_new  = (recalibrate ? '0 : sum_q) + SUM_W'(adc_mv);
		cnt_new  = (recalibrate ? '0 : cnt_q) + CNT_W'(1);
		win_reg  = cal_next ? cfg.zero_samples : cfg.read_samples;
		priority if (win_reg == '0) begin
			win_len = CNT_W'(1);
		end else if (32'(win_reg) > 32'(MAX_WINDOW)) begin
			win_len = CNT_W'(MAX_WINDOW);
		end else begin
			win_len = CNT_W'(win_reg);
		end
		// a shortened window closes on the next sample
		win_done = (cnt_new >= win_len);
	end

	assign job_push = take && win_done;
	assign job_kind = cal_next ? KIND_CAL : KIND_MEAS;
	assign job_sum  = sum_new;
	assign job_cnt  = cnt_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= 1'b1;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (win_done) begin
				cal_q <= 1'b0;
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				cal_q <= cal_next;
				sum_q <= sum_new;
				cnt_q <= cnt_new;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/csa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_back
// Window evaluator: serial divide for the mean, divider correction, zero
// level check or current scaling, and result write into the output queue.
// ----------------------------------------------------------------------------
module csa_back #(
	parameter int MAX_WINDOW = csa_pkg::MAX_WINDOW_DEF,
	parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
	parameter int SUM_W      = csa_pkg::MV_W + CNT_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csa_pkg::cfg_t       cfg,
	input  logic                job_empty,
	input  logic                job_kind,
	input  logic [SUM_W-1:0]    job_sum,
	input  logic [CNT_W-1:0]    job_cnt,
	output logic                job_pop,
	input  logic                res_full,
	output logic                res_push,
	output csa_pkg::result_t    res
);
	import csa_pkg::*;

	localparam int BIT_W   = $clog2(SUM_W);
	localparam int PROD1_W = MV_W + COEF_W;
	localparam int PROD2_W = LEVEL_W + COEF_W;
	localparam int CUR_W   = PROD2_W - GAIN_FRAC;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL1,
		S_LVL,
		S_MUL2,
		S_FIN
	} state_t;

	state_t             state_q;
	logic               kind_q;
	logic [CNT_W:0]     rem_q;
	logic [SUM_W-1:0]   quo_q;
	logic [CNT_W-1:0]   div_q;
	logic [BIT_W-1:0]   bit_q;
	logic [PROD1_W-1:0] prod1_q;
	logic [PROD2_W-1:0] prod2_q;
	logic [LEVEL_W-1:0] diff_q;
	logic [LEVEL_W-1:0] zero_q;
	logic               ready_q;

	logic [CNT_W:0]     rem_sh;
	logic               rem_ge;
	logic [LEVEL_W-1:0] lvl;
	logic               lvl_ok;
	logic [CUR_W-1:0]   cur_full;
	logic [COEF_W-1:0]  cur_sat;
	logic [COEF_W-1:0]  cur_out;

	always_comb begin
		rem_sh   = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
		rem_ge   = (rem_sh >= {1'b0, div_q});
		lvl      = prod1_q[PROD1_W-1:LEVEL_FRAC];
		lvl_ok   = (lvl >= ZERO_MIN_MV) && (lvl <= ZERO_MAX_MV);
		cur_full = prod2_q[PROD2_W-1:GAIN_FRAC];
		cur_sat  = (cur_full > CUR_W'({COEF_W{1'b1}})) ? {COEF_W{1'b1}}
		                                                 : cur_full[COEF_W-1:0];
		// drop readings under the noise floor, and all of them when not ready
		cur_out  = (!ready_q || (cur_sat < cfg.noise_floor_ma)) ? '0 : cur_sat;
	end

	assign job_pop = (state_q == S_IDLE) && !job_empty && !res_full;

	always_comb begin
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			S_LVL: begin
				if (kind_q == KIND_CAL) begin
					res_push          = 1'b1;
					res.kind          = KIND_CAL;
					res.ok            = lvl_ok;
					res.zero_level_mv = lvl;
				end
			end
			S_FIN: begin
				res_push          = 1'b1;
				res.kind          = KIND_MEAS;
				res.ok            = ready_q;
				res.current_ma    = cur_out;
				res.zero_level_mv = zero_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			zero_q  <= '0;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_pop) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= S_LVL;
				end
				S_LVL: begin
					if (kind_q == KIND_CAL) begin
						zero_q  <= lvl;
						ready_q <= lvl_ok;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			kind_q <= job_kind;
			rem_q  <= '0;
			quo_q  <= job_sum;
			div_q  <= job_cnt;
			bit_q  <= BIT_W'(SUM_W - 1);
		end
		if (state_q == S_DIV) begin
			rem_q <= rem_ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
			quo_q <= {quo_q[SUM_W-2:0], rem_ge};
			bit_q <= bit_q - 1'b1;
		end
		if (state_q == S_MUL1) begin
			// the mean never exceeds one sample, so it fits the sample width
			prod1_q <= PROD1_W'(quo_q[MV_W-1:0]) * PROD1_W'(cfg.divider_inv_q12);
		end
		if (state_q == S_LVL) begin
			diff_q <= (lvl >= zero_q) ? (lvl - zero_q) : (zero_q - lvl);
		end
		if (state_q == S_MUL2) begin
			prod2_q <= PROD2_W'(diff_q) * PROD2_W'(cfg.ma_per_mv_q8);
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < {1'b0, div_q}))
		else $error("divider remainder out of range");

	a_pop_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (state_q == S_DIV))
		else $error("window taken without starting the divide");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_q != '0))
		else $error("window with zero samples");

endmodule
`default_nettype wire

// ===== design/current_sensor_averager_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// current_sensor_averager_unit
// Hall current sensor zero calibration and windowed current measurement.
// ----------------------------------------------------------------------------
// Each pushed request is one ADC sample; it is added to the running sum, and
// the input takes a new sample every cycle while the window queue has room.
// A finished window goes to the back end for restoring division, divider
// correction and the zero level check, plus current scaling for a current
// result; the back end takes no new window before it has written the last
// result. Up to two windows wait between the accumulator and the divider and
// up to two results wait at the output, so samples keep flowing while results
// are not popped until both queues fill. The first window after reset, or the
// window begun by a sample with recalibrate set, yields the zero level.
module current_sensor_averager_unit #(
	parameter int MAX_WINDOW = csa_pkg::MAX_WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [csa_pkg::MV_W-1:0]      adc_mv,
	input  logic                          recalibrate,
	output logic                          empty,
	input  logic                          pop,
	output logic                          result_kind,
	output logic                          sensor_ok,
	output logic [csa_pkg::COEF_W-1:0]    current_ma,
	output logic [csa_pkg::LEVEL_W-1:0]   zero_level_mv,
	input  logic                          cfg_wen,
	input  logic [csa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [csa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import csa_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = MV_W + CNT_W;
	localparam int JOB_W = 1 + SUM_W + CNT_W;

	cfg_t             cfg_q;
	logic             take;
	logic             job_push;
	logic             job_kind;
	logic [SUM_W-1:0] job_sum;
	logic [CNT_W-1:0] job_cnt;
	logic             job_full;
	logic             job_empty;
	logic             job_pop;
	logic [JOB_W-1:0] job_head;
	logic             res_full;
	logic             res_push;
	result_t          res_in;
	result_t          res_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_samples    <= ZERO_SAMPLES_RST;
			cfg_q.read_samples    <= READ_SAMPLES_RST;
			cfg_q.divider_inv_q12 <= DIVIDER_INV_RST;
			cfg_q.ma_per_mv_q8    <= MA_PER_MV_RST;
			cfg_q.noise_floor_ma  <= NOISE_FLOOR_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ZERO_SAMPLES: cfg_q.zero_samples    <= cfg_wdata[WIN_REG_W-1:0];
				REG_READ_SAMPLES: cfg_q.read_samples    <= cfg_wdata[WIN_REG_W-1:0];
				REG_DIVIDER_INV:  cfg_q.divider_inv_q12 <= cfg_wdata[COEF_W-1:0];
				REG_MA_PER_MV:    cfg_q.ma_per_mv_q8    <= cfg_wdata[COEF_W-1:0];
				REG_NOISE_FLOOR:  cfg_q.noise_floor_ma  <= cfg_wdata[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign full = job_full;
	assign take = push && !job_full;

	csa_front #(
		.MAX_WINDOW (MAX_WINDOW),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.adc_mv      (adc_mv),
		.recalibrate (recalibrate),
		.cfg         (cfg_q),
		.job_push    (job_push),
		.job_kind    (job_kind),
		.job_sum     (job_sum),
		.job_cnt     (job_cnt)
	);

	csa_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  ({job_kind, job_sum, job_cnt}),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_head),
		.empty  (job_empty)
	);

	csa_back #(
		.MAX_WINDOW (MAX_WINDOW),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job_kind  (job_head[JOB_W-1]),
		.job_sum   (job_head[JOB_W-2:CNT_W]),
		.job_cnt   (job_head[CNT_W-1:0]),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	csa_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign result_kind   = res_head.kind;
	assign sensor_ok     = res_head.ok;
	assign current_ma    = res_head.current_ma;
	assign zero_level_mv = res_head.zero_level_mv;

endmodule
`default_nettype wire
